[hdl/tcc_pkg.sv]
// shared types and constants of the trajectory constraint cost block
`default_nettype none

package tcc_pkg;

  // restoring divider: one quotient bit per cycle for a 40-bit quotient
  localparam int DIV_STEPS = 40;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // 48x48 product from four 24x24 partial products and a final drain step for the last add
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);

  localparam logic [47:0] LIM48 = 48'hFFFF_FFFF_FFFF;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ENABLE     = 3'd0,
    CFG_MAX_SPEED  = 3'd1,
    CFG_MIN_SPEED  = 3'd2,
    CFG_MIN_RADIUS = 3'd3,
    CFG_STEP_TIME  = 3'd4,
    CFG_WEIGHT     = 3'd5,
    CFG_POWER      = 3'd6
  } cfg_idx_t;

  // configuration reset values
  localparam logic        ENABLE_RST     = 1'b1;
  localparam logic [23:0] MAX_SPEED_RST  = 24'h008000;
  localparam logic [23:0] MIN_SPEED_RST  = 24'hFFA666;
  localparam logic [23:0] MIN_RADIUS_RST = 24'h000000;
  localparam logic [15:0] STEP_TIME_RST  = 16'h0CCD;
  localparam logic [23:0] WEIGHT_RST     = 24'h040000;
  localparam logic [2:0]  POWER_RST      = 3'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_VIOL,
    ST_MUL_STEP,
    ST_ACCUM,
    ST_MUL_BASE,
    ST_BASE_TAKE,
    ST_MUL_POW,
    ST_POW_TAKE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       viol_load;
    logic       mul_clr;
    logic       mul_pp;
    logic       mul_acc;
    logic [1:0] mul_idx;
    logic       sum_acc;
    logic       base_load;
    logic       base_take;
    logic       pow_take;
    logic       emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       enable;
    logic       last;
    logic [2:0] cost_power;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

[hdl/trajectory_constraint_cost.sv]
// top level of the trajectory constraint cost block
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   speed, yaw_rate, prior_cost, last_step
//   out      output     out_valid / out_ready total_cost, saturated
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// enabled step: accept, the restoring divider iterations for the turning radius,
// violation, the partial products on the shared 24x24 multiplier, accumulate
// last step then forms the weighted base and raises it to power p on the multiplier,
// then emits after any wait on out_ready; disabled: accept, last step also emits
// reset clears control, configuration and violation sum; cfg writes are always taken
`default_nettype none

module trajectory_constraint_cost #(
  parameter int MAX_POWER = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] speed,
  input  wire logic signed [23:0] yaw_rate,
  input  wire logic [47:0]        prior_cost,
  input  wire logic               last_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [47:0]             total_cost,
  output logic                    saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  tcc_pkg::cmd_t    cmd;
  tcc_pkg::status_t status;

  // configuration is always writable
  assign cfg_ready = 1'b1;

  tcc_ctrl #(
    .MAX_POWER (MAX_POWER)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_step (last_step),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tcc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .speed      (speed),
    .yaw_rate   (yaw_rate),
    .prior_cost (prior_cost),
    .last_step  (last_step),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .total_cost (total_cost),
    .saturated  (saturated),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire

[hdl/tcc_ctrl.sv]
// sequencer for division, shared multiplier and result emission
`default_nettype none

module tcc_ctrl #(
  parameter int MAX_POWER = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             last_step,
  output logic                  in_ready,
  input  wire tcc_pkg::status_t status,
  output tcc_pkg::cmd_t         cmd
);

  localparam int PW = $clog2(MAX_POWER + 1);

  tcc_pkg::state_t              state, state_next;
  logic [tcc_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic [PW-1:0]                pw_cnt, pw_cnt_next;
  logic [PW-1:0]                pw_load;
  logic                         mul_state;

  // number of extra multiplications after the weighted base
  always_comb begin
    int pe;
    pe = (status.cost_power == 3'd0) ? 1 : int'(status.cost_power);
    if (pe > MAX_POWER) begin
      pe = MAX_POWER;
    end
    pw_load = PW'(pe - 1);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tcc_pkg::ST_IDLE;
      cnt    <= '0;
      pw_cnt <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      pw_cnt <= pw_cnt_next;
    end
  end

  assign mul_state = (state == tcc_pkg::ST_MUL_STEP) || (state == tcc_pkg::ST_MUL_BASE) ||
                     (state == tcc_pkg::ST_MUL_POW);

  // next state and commands
  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    pw_cnt_next = pw_cnt;
    cmd         = '0;
    in_ready    = (state == tcc_pkg::ST_IDLE);

    // shared multiplier schedule: products at 0..3, adds at 1..4
    if (mul_state) begin
      cmd.mul_idx = cnt[1:0];
      cmd.mul_clr = (cnt == '0);
      cmd.mul_pp  = (cnt != tcc_pkg::MUL_LAST);
      cmd.mul_acc = (cnt != '0);
      cnt_next    = (cnt == tcc_pkg::MUL_LAST) ? '0 : cnt + 1'b1;
    end

    case (state)
      tcc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_next = '0;
          if (status.enable) begin
            state_next = tcc_pkg::ST_DIV;
          end else if (last_step) begin
            state_next = tcc_pkg::ST_EMIT;
          end
        end
      end
      tcc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == tcc_pkg::CNT_W'(tcc_pkg::DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = tcc_pkg::ST_VIOL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      tcc_pkg::ST_VIOL: begin
        cmd.viol_load = 1'b1;
        state_next    = tcc_pkg::ST_MUL_STEP;
      end
      tcc_pkg::ST_MUL_STEP: begin
        if (cnt == tcc_pkg::MUL_LAST) begin
          state_next = tcc_pkg::ST_ACCUM;
        end
      end
      tcc_pkg::ST_ACCUM: begin
        cmd.sum_acc = 1'b1;
        if (status.last) begin
          cmd.base_load = 1'b1;
          state_next    = tcc_pkg::ST_MUL_BASE;
        end else begin
          state_next = tcc_pkg::ST_IDLE;
        end
      end
      tcc_pkg::ST_MUL_BASE: begin
        if (cnt == tcc_pkg::MUL_LAST) begin
          state_next = tcc_pkg::ST_BASE_TAKE;
        end
      end
      tcc_pkg::ST_BASE_TAKE: begin
        cmd.base_take = 1'b1;
        if (pw_load == '0) begin
          state_next = tcc_pkg::ST_EMIT;
        end else begin
          pw_cnt_next = pw_load;
          state_next  = tcc_pkg::ST_MUL_POW;
        end
      end
      tcc_pkg::ST_MUL_POW: begin
        if (cnt == tcc_pkg::MUL_LAST) begin
          state_next = tcc_pkg::ST_POW_TAKE;
        end
      end
      tcc_pkg::ST_POW_TAKE: begin
        cmd.pow_take = 1'b1;
        pw_cnt_next  = pw_cnt - 1'b1;
        if (pw_cnt == PW'(1)) begin
          state_next = tcc_pkg::ST_EMIT;
        end else begin
          state_next = tcc_pkg::ST_MUL_POW;
        end
      end
      tcc_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = tcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcc_pkg::ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a pending result is never overwritten
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.out_free)
    else $error("emit while output register still holds a result");

  // a disabled non-final step is back in idle in the cycle after it is accepted
  a_disabled_step: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !status.enable && !last_step) |=> (state == tcc_pkg::ST_IDLE))
    else $error("disabled step did not return to idle");

  // divider count stays within the quotient length
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == tcc_pkg::ST_DIV) |-> (int'(cnt) < tcc_pkg::DIV_STEPS))
    else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire

[hdl/tcc_datapath.sv]
// configuration registers, radius divider, shared multiplier, sum and output register
`default_nettype none

module tcc_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration writes
  input  wire logic                cfg_valid,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [23:0]         cfg_data,
  // input request fields
  input  wire logic signed [23:0]  speed,
  input  wire logic signed [23:0]  yaw_rate,
  input  wire logic [47:0]         prior_cost,
  input  wire logic                last_step,
  // output request
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [47:0]              total_cost,
  output logic                     saturated,
  // controller link
  input  wire tcc_pkg::cmd_t       cmd,
  output tcc_pkg::status_t         status
);

  // configuration registers
  logic               enable;
  logic signed [23:0] max_speed;
  logic signed [23:0] min_speed;
  logic [23:0]        min_radius;
  logic [15:0]        step_time;
  logic [23:0]        cost_weight;
  logic [2:0]         cost_power;

  // step operands and divider
  logic signed [23:0] s_q;
  logic [23:0]        dvs;
  logic [23:0]        rem;
  logic [39:0]        nq;
  logic [47:0]        prior_q;
  logic               last_q;

  // multiplier and accumulation
  logic [47:0]        mul_a, mul_b;
  logic [47:0]        pp;
  logic [1:0]         pp_idx;
  logic [95:0]        prod;
  logic [47:0]        vsum;
  logic               sat_q;

  logic [23:0]        abs_s, abs_w;
  logic [24:0]        rem_sh;
  logic               q_bit;
  logic [24:0]        d_over, d_under;
  logic [23:0]        d_rad;
  logic [25:0]        viol;
  logic [23:0]        a_sel, b_sel;
  logic [95:0]        pp_sh;
  logic               prod_ovf;
  logic [47:0]        prod_val;
  logic [48:0]        sum49;
  logic [47:0]        sum_new;
  logic [48:0]        tot49;

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= tcc_pkg::ENABLE_RST;
      max_speed   <= tcc_pkg::MAX_SPEED_RST;
      min_speed   <= tcc_pkg::MIN_SPEED_RST;
      min_radius  <= tcc_pkg::MIN_RADIUS_RST;
      step_time   <= tcc_pkg::STEP_TIME_RST;
      cost_weight <= tcc_pkg::WEIGHT_RST;
      cost_power  <= tcc_pkg::POWER_RST;
    end else if (cfg_valid) begin
      case (tcc_pkg::cfg_idx_t'(cfg_index))
        tcc_pkg::CFG_ENABLE:     enable      <= cfg_data[0];
        tcc_pkg::CFG_MAX_SPEED:  max_speed   <= cfg_data;
        tcc_pkg::CFG_MIN_SPEED:  min_speed   <= cfg_data;
        tcc_pkg::CFG_MIN_RADIUS: min_radius  <= cfg_data;
        tcc_pkg::CFG_STEP_TIME:  step_time   <= cfg_data[15:0];
        tcc_pkg::CFG_WEIGHT:     cost_weight <= cfg_data;
        tcc_pkg::CFG_POWER:      cost_power  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // magnitudes; the most negative value maps to 2^23
  assign abs_s = speed[23] ? (~speed + 24'd1) : speed;
  assign abs_w = yaw_rate[23] ? (~yaw_rate + 24'd1) : yaw_rate;

  // one restoring division step
  assign rem_sh = {rem, nq[39]};
  assign q_bit  = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_q     <= speed;
      dvs     <= (abs_w == '0) ? 24'd1 : abs_w;
      rem     <= '0;
      nq      <= {abs_s, 16'd0};
      prior_q <= prior_cost;
      last_q  <= last_step;
    end else if (cmd.div_step) begin
      rem <= q_bit ? 24'(rem_sh - {1'b0, dvs}) : rem_sh[23:0];
      nq  <= {nq[38:0], q_bit};
    end
  end

  // per-step violation from the speed limits and the radius shortfall
  assign d_over  = {s_q[23], s_q} - {max_speed[23], max_speed};
  assign d_under = {min_speed[23], min_speed} - {s_q[23], s_q};
  assign d_rad   = min_radius - nq[23:0];
  assign viol    = ((s_q > max_speed) ? {2'b00, d_over[23:0]} : 26'd0) +
                   ((min_speed > s_q) ? {2'b00, d_under[23:0]} : 26'd0) +
                   ((nq < {16'd0, min_radius}) ? {2'b00, d_rad} : 26'd0);

  // partial product operand halves
  assign a_sel = cmd.mul_idx[1] ? mul_a[47:24] : mul_a[23:0];
  assign b_sel = cmd.mul_idx[0] ? mul_b[47:24] : mul_b[23:0];

  always_comb begin
    case (pp_idx)
      2'd0:    pp_sh = {48'd0, pp};
      2'd3:    pp_sh = {pp, 48'd0};
      default: pp_sh = {24'd0, pp, 24'd0};
    endcase
  end

  // Q.16 truncation with clip at the 48-bit limit
  assign prod_ovf = |prod[95:64];
  assign prod_val = prod_ovf ? tcc_pkg::LIM48 : prod[63:16];

  // saturating violation sum
  assign sum49   = {1'b0, vsum} + {1'b0, prod[63:16]};
  assign sum_new = sum49[48] ? tcc_pkg::LIM48 : sum49[47:0];

  // final total
  assign tot49 = {1'b0, prior_q} + {1'b0, mul_a};

  // multiplier pipeline: product register, then shifted add
  always_ff @(posedge clk) begin
    if (cmd.mul_pp) begin
      pp     <= a_sel * b_sel;
      pp_idx <= cmd.mul_idx;
    end
    if (cmd.mul_clr) begin
      prod <= '0;
    end else if (cmd.mul_acc) begin
      prod <= prod + pp_sh;
    end
  end

  // multiplier operands and power chain
  always_ff @(posedge clk) begin
    if (cmd.viol_load) begin
      mul_a <= {22'd0, viol};
      mul_b <= {32'd0, step_time};
    end else if (cmd.base_load) begin
      mul_a <= sum_new;
      mul_b <= {24'd0, cost_weight};
    end else if (cmd.base_take) begin
      mul_a <= prod_val;
      mul_b <= prod_val;
      sat_q <= prod_ovf;
    end else if (cmd.pow_take) begin
      mul_a <= prod_val;
      sat_q <= sat_q | prod_ovf;
    end
  end

  // violation sum, cleared by every emitted result
  always_ff @(posedge clk) begin
    if (rst) begin
      vsum <= '0;
    end else if (cmd.emit) begin
      vsum <= '0;
    end else if (cmd.sum_acc) begin
      vsum <= sum_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (enable) begin
        total_cost <= tot49[48] ? tcc_pkg::LIM48 : tot49[47:0];
        saturated  <= sat_q | tot49[48];
      end else begin
        total_cost <= prior_q;
        saturated  <= 1'b0;
      end
    end
  end

  // status to controller
  assign status.enable     = enable;
  assign status.last       = last_q;
  assign status.cost_power = cost_power;
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire
